[rtl/core/rpn_stack_evaluator_unit_assert.svh]
// Assertion macros for the RPN stack evaluator.
// Both sample on clk and are disabled while rst_n is low.
`ifndef RPN_STACK_EVALUATOR_UNIT_ASSERT_SVH
`define RPN_STACK_EVALUATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSE_ASSERT_SAME(lbl, ante, cons, msg)
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/rse_pkg.sv]
package rse_pkg;

    localparam logic [4:0] CMD_LIT  = 5'd0;
    localparam logic [4:0] CMD_VART = 5'd1;
    localparam logic [4:0] CMD_SWAP = 5'd2;
    localparam logic [4:0] CMD_DUP  = 5'd3;
    localparam logic [4:0] CMD_PUT  = 5'd4;
    localparam logic [4:0] CMD_PICK = 5'd5;
    localparam logic [4:0] CMD_ONLY = 5'd6;
    localparam logic [4:0] CMD_DROP = 5'd7;
    localparam logic [4:0] CMD_NOT  = 5'd8;
    localparam logic [4:0] CMD_ADD  = 5'd9;
    localparam logic [4:0] CMD_SUB  = 5'd10;
    localparam logic [4:0] CMD_MUL  = 5'd11;
    localparam logic [4:0] CMD_DIV  = 5'd12;
    localparam logic [4:0] CMD_MOD  = 5'd13;
    localparam logic [4:0] CMD_EQ   = 5'd14;
    localparam logic [4:0] CMD_NE   = 5'd15;
    localparam logic [4:0] CMD_GT   = 5'd16;
    localparam logic [4:0] CMD_LT   = 5'd17;
    localparam logic [4:0] CMD_GE   = 5'd18;
    localparam logic [4:0] CMD_LE   = 5'd19;
    localparam logic [4:0] CMD_LAND = 5'd20;
    localparam logic [4:0] CMD_LOR  = 5'd21;
    localparam logic [4:0] CMD_SHL  = 5'd22;
    localparam logic [4:0] CMD_SHR  = 5'd23;
    localparam logic [4:0] CMD_AND  = 5'd24;
    localparam logic [4:0] CMD_OR   = 5'd25;
    localparam logic [4:0] CMD_XOR  = 5'd26;
    localparam logic [4:0] CMD_NOP  = 5'd27;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISSING    = 3'd1;
    localparam logic [2:0] ST_INDEX      = 3'd2;
    localparam logic [2:0] ST_DIVZERO    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;
    localparam logic [2:0] ST_INCOMPLETE = 3'd5;
    localparam logic [2:0] ST_EMPTY      = 3'd6;
    localparam logic [2:0] ST_OVERFLOW   = 3'd7;

    localparam logic [0:0] REG_VART  = 1'b0;
    localparam logic [0:0] REG_ALLOW = 1'b1;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] literal_value;
        logic               last_token;
    } tok_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
    } res_t;

endpackage

[rtl/core/rpn_stack_evaluator_unit.sv]
// Flow: push/drop/nop and skipped tokens (after an error): decode, finish; dup/not
// also read the top; pick/only add an index step, put an operand read, swap also a
// write-back, other binary operators an ALU step, div/mod a 32-step shift-subtract
// divider, sign fix; the last token adds a top read for the result, plus any wait
// on an unaccepted previous result. One token at a time, taken only in idle.
// Reset: rst_n asynchronous active low; empties the stack, clears the error.
module rpn_stack_evaluator_unit
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    output logic        tok_ready,
    input  tok_t        tok,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RDB, S_RDA, S_IDX, S_OPA,
        S_ALU, S_DIV, S_DFIX, S_WB, S_FIN, S_FRD
    } state_t;

    state_t state_reg;
    tok_t   tok_reg;
    res_t   out_reg;
    logic   out_valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2:0]  err_reg;
    logic [31:0] var_t_reg;
    logic        allow_reg;
    logic [31:0] a_reg, b_reg, acc_reg;
    logic [31:0] div_q_reg, div_rem_reg, div_dvs_reg;
    logic [4:0]  div_step_reg;

    // Stack memory: one write and one registered read per cycle.
    logic [31:0] stack_mem [STACK_DEPTH];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= stack_mem[mem_raddr];
        end
    end

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALLOW) ? {31'd0, allow_reg} : var_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_t_reg <= '0;
            allow_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_VART)
            begin
                var_t_reg <= pwdata;
            end
            else
            begin
                allow_reg <= pwdata[0];
            end
        end
    end

    // Decode helpers
    logic [4:0]  cmd;
    logic [1:0]  need;
    logic        missing, unknown, dec_go, full;
    logic [ADDR_W-1:0] top_addr, sec_addr, cnt_addr;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic        idx1_bad, idx2_bad;
    logic [ADDR_W-1:0] slot1_addr, slot2_addr;
    logic        out_free, fin_ok, res_load;
    logic [32:0] div_shift, div_trial;
    logic [31:0] mag_a, mag_b;

    assign cmd = tok_reg.command;

    always_comb
    begin
        need = 2'd0;
        if (cmd == CMD_SWAP || cmd == CMD_PUT || cmd >= CMD_ADD)
        begin
            need = 2'd2;
        end
        else if (cmd >= CMD_DUP)
        begin
            need = 2'd1;
        end
        if (cmd == CMD_NOP)
        begin
            need = 2'd0;
        end
    end

    assign missing  = cnt_reg < CNT_W'(need);
    assign unknown  = cmd > CMD_NOP;
    assign dec_go   = (err_reg == ST_OK) && (cmd != CMD_NOP) && !missing;
    assign full     = cnt_reg >= DEPTH_C;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign top_addr = cnt_m1[ADDR_W-1:0];
    assign sec_addr = cnt_m2[ADDR_W-1:0];
    assign cnt_addr = cnt_reg[ADDR_W-1:0];

    // pick/only: index from the memory read; put: index held in b_reg
    assign idx1_bad   = mem_rdata[31] || (mem_rdata >= 32'(cnt_m1));
    assign idx2_bad   = b_reg[31] || (b_reg >= 32'(cnt_m2));
    assign slot1_addr = ADDR_W'(cnt_m2 - mem_rdata[CNT_W-1:0]);
    assign slot2_addr = ADDR_W'(cnt_m2 - CNT_W'(1) - b_reg[CNT_W-1:0]);

    assign out_free = !out_valid_reg || res_ready;
    assign fin_ok   = (err_reg == ST_OK) && !(!allow_reg && cnt_reg != CNT_W'(1))
                      && (cnt_reg != '0);
    // result register loads on an error close or in S_FRD, after the top read
    assign res_load = (state_reg == S_FRD)
                      || (state_reg == S_FIN && tok_reg.last_token && out_free && !fin_ok);

    assign mag_a = mem_rdata[31] ? (32'd0 - mem_rdata) : mem_rdata;
    assign mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;

    // Restoring divider step: one quotient bit per cycle
    assign div_shift = {div_rem_reg, div_q_reg[31]};
    assign div_trial = div_shift - {1'b0, div_dvs_reg};

    // Memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = top_addr;
        mem_raddr = top_addr;
        mem_wdata = mem_rdata;
        case (state_reg)
            S_DECODE:
            begin
                if (dec_go && !full && (cmd == CMD_LIT || cmd == CMD_VART))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_addr;
                    mem_wdata = (cmd == CMD_LIT) ? tok_reg.literal_value : var_t_reg;
                end
            end
            S_RDB:
            begin
                mem_re = 1'b1;
            end
            S_RDA:
            begin
                case (cmd)
                    CMD_DUP:
                    begin
                        mem_we    = !full;
                        mem_waddr = cnt_addr;
                    end
                    CMD_NOT:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = ~mem_rdata;
                    end
                    CMD_PICK, CMD_ONLY:
                    begin
                        mem_re    = !idx1_bad;
                        mem_raddr = slot1_addr;
                    end
                    default:
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = sec_addr;
                    end
                endcase
            end
            S_IDX:
            begin
                mem_we = 1'b1;
                if (cmd == CMD_ONLY)
                begin
                    mem_waddr = '0;
                end
            end
            S_OPA:
            begin
                if (cmd == CMD_SWAP)
                begin
                    mem_we = 1'b1;
                end
                else if (cmd == CMD_PUT)
                begin
                    mem_we    = !idx2_bad;
                    mem_waddr = slot2_addr;
                end
            end
            S_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = sec_addr;
                mem_wdata = acc_reg;
            end
            S_FIN:
            begin
                mem_re = tok_reg.last_token && out_free && fin_ok;
            end
            default:
            begin
            end
        endcase
    end

    // Operator unit, registered operands in and acc_reg out
    logic [31:0] alu_out;
    always_comb
    begin
        case (cmd)
            CMD_ADD:  alu_out = a_reg + b_reg;
            CMD_SUB:  alu_out = a_reg - b_reg;
            CMD_MUL:  alu_out = a_reg * b_reg;
            CMD_EQ:   alu_out = {31'd0, a_reg == b_reg};
            CMD_NE:   alu_out = {31'd0, a_reg != b_reg};
            CMD_GT:   alu_out = {31'd0, $signed(a_reg) > $signed(b_reg)};
            CMD_LT:   alu_out = {31'd0, $signed(a_reg) < $signed(b_reg)};
            CMD_GE:   alu_out = {31'd0, $signed(a_reg) >= $signed(b_reg)};
            CMD_LE:   alu_out = {31'd0, $signed(a_reg) <= $signed(b_reg)};
            CMD_LAND: alu_out = {31'd0, (a_reg != 0) && (b_reg != 0)};
            CMD_LOR:  alu_out = {31'd0, (a_reg != 0) || (b_reg != 0)};
            CMD_SHL:  alu_out = a_reg << b_reg[4:0];
            CMD_SHR:  alu_out = 32'($signed(a_reg) >>> b_reg[4:0]);
            CMD_AND:  alu_out = a_reg & b_reg;
            CMD_OR:   alu_out = a_reg | b_reg;
            default:  alu_out = a_reg ^ b_reg;
        endcase
    end

    assign tok_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (tok_valid)
                    begin
                        tok_reg   <= tok;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_FIN;
                    if (err_reg == ST_OK && cmd != CMD_NOP)
                    begin
                        if (missing)
                        begin
                            err_reg <= ST_MISSING;
                        end
                        else if (unknown)
                        begin
                            err_reg <= ST_UNKNOWN;
                        end
                        else if (cmd == CMD_LIT || cmd == CMD_VART)
                        begin
                            if (full)
                            begin
                                err_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                        end
                        else if (cmd == CMD_DROP)
                        begin
                            cnt_reg <= cnt_m1;
                        end
                        else
                        begin
                            state_reg <= S_RDB;
                        end
                    end
                end
                S_RDB:
                begin
                    state_reg <= S_RDA;
                end
                S_RDA:
                begin
                    b_reg <= mem_rdata;
                    case (cmd)
                        CMD_DUP:
                        begin
                            if (full)
                            begin
                                err_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                            state_reg <= S_FIN;
                        end
                        CMD_NOT:
                        begin
                            state_reg <= S_FIN;
                        end
                        CMD_PICK, CMD_ONLY:
                        begin
                            if (idx1_bad)
                            begin
                                err_reg   <= ST_INDEX;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                state_reg <= S_IDX;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_OPA;
                        end
                    endcase
                end
                S_IDX:
                begin
                    // pick replaces the popped index with the picked entry
                    if (cmd == CMD_ONLY)
                    begin
                        cnt_reg <= CNT_W'(1);
                    end
                    state_reg <= S_FIN;
                end
                S_OPA:
                begin
                    a_reg <= mem_rdata;
                    case (cmd)
                        CMD_SWAP:
                        begin
                            acc_reg   <= b_reg;
                            state_reg <= S_WB;
                        end
                        CMD_PUT:
                        begin
                            cnt_reg <= cnt_m2;
                            if (idx2_bad)
                            begin
                                err_reg <= ST_INDEX;
                            end
                            state_reg <= S_FIN;
                        end
                        CMD_DIV, CMD_MOD:
                        begin
                            if (b_reg == '0)
                            begin
                                err_reg   <= ST_DIVZERO;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                div_q_reg    <= mag_a;
                                div_rem_reg  <= '0;
                                div_dvs_reg  <= mag_b;
                                div_step_reg <= '0;
                                state_reg    <= S_DIV;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_ALU;
                        end
                    endcase
                end
                S_ALU:
                begin
                    acc_reg   <= alu_out;
                    state_reg <= S_WB;
                end
                S_DIV:
                begin
                    if (!div_trial[32])
                    begin
                        div_rem_reg <= div_trial[31:0];
                        div_q_reg   <= {div_q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= div_shift[31:0];
                        div_q_reg   <= {div_q_reg[30:0], 1'b0};
                    end
                    div_step_reg <= div_step_reg + 5'd1;
                    if (div_step_reg == 5'd31)
                    begin
                        state_reg <= S_DFIX;
                    end
                end
                S_DFIX:
                begin
                    // quotient sign from both operands, remainder follows a
                    if (cmd == CMD_DIV)
                    begin
                        acc_reg <= (a_reg[31] ^ b_reg[31]) ? (32'd0 - div_q_reg)
                                                           : div_q_reg;
                    end
                    else
                    begin
                        acc_reg <= a_reg[31] ? (32'd0 - div_rem_reg) : div_rem_reg;
                    end
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (cmd != CMD_SWAP)
                    begin
                        cnt_reg <= cnt_m1;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!tok_reg.last_token)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        if (fin_ok)
                        begin
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            out_reg.result_value <= '0;
                            if (err_reg != ST_OK)
                            begin
                                out_reg.status <= err_reg;
                            end
                            else if (!allow_reg && cnt_reg != CNT_W'(1))
                            begin
                                out_reg.status <= ST_INCOMPLETE;
                            end
                            else
                            begin
                                out_reg.status <= ST_EMPTY;
                            end
                            cnt_reg       <= '0;
                            err_reg       <= ST_OK;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_FRD:
                begin
                    out_reg.result_value <= mem_rdata;
                    out_reg.status       <= ST_OK;
                    cnt_reg              <= '0;
                    err_reg              <= ST_OK;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "rpn_stack_evaluator_unit_assert.svh"

    `RSE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= DEPTH_C, "stack count beyond depth")
    `RSE_ASSERT_NEXT(a_one_token, tok_valid && tok_ready, !tok_ready, "token taken while busy")
    `RSE_ASSERT_SAME(a_div_nonzero, state_reg == S_DIV, b_reg != '0, "divider run on zero")
    `RSE_ASSERT_SAME(a_res_last, $rose(out_valid_reg), tok_reg.last_token, "result not on last")

endmodule

[tb/sv/rpn_result_checker.sv]
module rpn_result_checker
    import rse_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    input  logic        tok_ready,
    input  tok_t        tok,
    input  logic        res_valid,
    input  logic        res_ready,
    input  res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          error_results
);

    logic [31:0] stk [STACK_DEPTH];
    int unsigned depth;
    logic [2:0]  err;
    logic [31:0] var_t;
    logic        allow_multi;
    res_t        expected_q[$];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %0d (0x%08h) want %0d (0x%08h)",
                 $realtime, what, $signed(got), got, $signed(want), want);
        fail_count++;
    endtask

    task automatic push_val(logic [31:0] v);
        if (depth >= STACK_DEPTH)
            err = ST_OVERFLOW;
        else
        begin
            stk[depth] = v;
            depth++;
        end
    endtask

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] alu(logic [4:0] cmd, logic [31:0] a, logic [31:0] b);
        logic [31:0] q;
        logic [4:0]  sh;
        sh = b[4:0];
        case (cmd)
            CMD_ADD:  return a + b;
            CMD_SUB:  return a - b;
            CMD_MUL:  return a * b;
            CMD_DIV:
            begin
                q = mag(a) / mag(b);
                return (a[31] ^ b[31]) ? -q : q;
            end
            CMD_MOD:
            begin
                q = mag(a) % mag(b);
                return a[31] ? -q : q;
            end
            CMD_EQ:   return {31'd0, a == b};
            CMD_NE:   return {31'd0, a != b};
            CMD_GT:   return {31'd0, $signed(a) > $signed(b)};
            CMD_LT:   return {31'd0, $signed(a) < $signed(b)};
            CMD_GE:   return {31'd0, $signed(a) >= $signed(b)};
            CMD_LE:   return {31'd0, $signed(a) <= $signed(b)};
            CMD_LAND: return {31'd0, (a != 0) && (b != 0)};
            CMD_LOR:  return {31'd0, (a != 0) || (b != 0)};
            CMD_SHL:  return a << sh;
            CMD_SHR:  return $signed(a) >>> sh;
            CMD_AND:  return a & b;
            CMD_OR:   return a | b;
            default:  return a ^ b;
        endcase
    endfunction

    // one token against the shadow stack
    task automatic exec_token(logic [4:0] cmd, logic [31:0] lit);
        int unsigned need;
        logic [31:0] a, b;
        need = 0;
        if (cmd == CMD_SWAP || cmd == CMD_PUT || (cmd >= CMD_ADD && cmd != CMD_NOP))
            need = 2;
        else if (cmd >= CMD_DUP && cmd != CMD_NOP)
            need = 1;
        if (depth < need)
        begin
            err = ST_MISSING;
            return;
        end
        case (cmd)
            CMD_LIT:  push_val(lit);
            CMD_VART: push_val(var_t);
            CMD_SWAP:
            begin
                a = stk[depth-1];
                stk[depth-1] = stk[depth-2];
                stk[depth-2] = a;
            end
            CMD_DUP:  push_val(stk[depth-1]);
            CMD_PUT:
            begin
                b = stk[depth-1];
                a = stk[depth-2];
                depth -= 2;
                if (b[31] || b >= depth)
                    err = ST_INDEX;
                else
                    stk[depth-1-b] = a;
            end
            CMD_PICK, CMD_ONLY:
            begin
                b = stk[depth-1];
                depth--;
                if (b[31] || b >= depth)
                    err = ST_INDEX;
                else if (cmd == CMD_PICK)
                    push_val(stk[depth-1-b]);
                else
                begin
                    stk[0] = stk[depth-1-b];
                    depth = 1;
                end
            end
            CMD_DROP: depth--;
            CMD_NOT:  stk[depth-1] = ~stk[depth-1];
            CMD_NOP:  ;
            default:
            begin
                if (cmd > CMD_NOP)
                    err = ST_UNKNOWN;
                else
                begin
                    b = stk[depth-1];
                    a = stk[depth-2];
                    depth -= 2;
                    if ((cmd == CMD_DIV || cmd == CMD_MOD) && b == 0)
                        err = ST_DIVZERO;
                    else
                        push_val(alu(cmd, a, b));
                end
            end
        endcase
    endtask

    task automatic finish_expr();
        res_t r;
        r.result_value = '0;
        if (err == ST_OK)
        begin
            if (!allow_multi && depth != 1)
                err = ST_INCOMPLETE;
            else if (depth == 0)
                err = ST_EMPTY;
            else
                r.result_value = stk[depth-1];
        end
        r.status = err;
        expected_q.push_back(r);
        depth = 0;
        err = ST_OK;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            depth = 0;
            err = ST_OK;
            var_t = '0;
            allow_multi = 1'b0;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (res.status != ST_OK)
                    error_results++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result, value", res.result_value, 32'd0);
                else
                begin
                    want = expected_q.pop_front();
                    if (res.result_value !== want.result_value)
                        report_mismatch("result_value", res.result_value, want.result_value);
                    if (res.status !== want.status)
                        report_mismatch("status", {29'd0, res.status}, {29'd0, want.status});
                end
            end
            if (tok_valid && tok_ready)
            begin
                if (err == ST_OK)
                    exec_token(tok.command, tok.literal_value);
                if (tok.last_token)
                    finish_expr();
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ALLOW)
                    allow_multi = pwdata[0];
                else
                    var_t = pwdata;
            end
            pending = expected_q.size();
        end
    end

    initial
    begin
        fail_count = 0;
        results_seen = 0;
        error_results = 0;
    end

endmodule

[tb/sv/tb.sv]
module tb;
    import rse_pkg::*;

    localparam int DEPTH = 1024;

    logic        clk;
    logic        rst_n;
    logic        tok_valid;
    logic        tok_ready;
    tok_t        tok;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_seen;
    int error_results;

    // token count and settings used, for the closing summary
    int tokens_sent;
    int settings_used;
    // shadow of allow_multiple_left, steers how expressions are closed
    logic allow_now;
    // when set, the sender runs back to back
    logic burst_mode;
    tok_t expr_q[$];

    rpn_stack_evaluator_unit #(.STACK_DEPTH(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    rpn_result_checker #(.STACK_DEPTH(DEPTH)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .tok           (tok),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .error_results (error_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Operand mix: extremes, tiny values and full-width noise.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 6))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, with idle-free stretches.
    initial
    begin
        int stall;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(50, 300)) @(negedge clk);
            end
            else
            begin
                stall = gap_len();
                if (stall == 0)
                    res_ready <= 1'b1;
                else
                begin
                    res_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // One transaction on the token channel; valid is held until accepted.
    task automatic send_tok(tok_t t);
        int g;
        @(negedge clk);
        tok <= t;
        tok_valid <= 1'b1;
        do
            @(posedge clk);
        while (!tok_ready);
        tokens_sent++;
        g = burst_mode ? 0 : gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            tok_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic queue_tok(logic [4:0] cmd, logic [31:0] lit);
        tok_t t;
        t.command = cmd;
        t.literal_value = lit;
        t.last_token = 1'b0;
        expr_q.push_back(t);
    endtask

    // Sends the queued expression with the final token marked last.
    task automatic send_expr();
        tok_t t;
        expr_q[expr_q.size() - 1].last_token = 1'b1;
        while (expr_q.size() > 0)
        begin
            t = expr_q.pop_front();
            send_tok(t);
        end
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        tok_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // APB write: setup then access; the register lands at the access edge.
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        drain();
        // a divide on a non-final token may still be running
        repeat (60) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ALLOW)
            allow_now = val[0];
        settings_used++;
    endtask

    // Builds a mostly well-formed random expression with tracked depth.
    task automatic build_expr();
        int d;
        int len;
        int r;
        logic [4:0] op;
        logic [31:0] idx;
        d = 0;
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (d < 2 || r < 30)
            begin
                if ($urandom_range(0, 6) == 0)
                    queue_tok(CMD_VART, $urandom);
                else
                    queue_tok(CMD_LIT, rand_operand());
                d++;
            end
            else if (r < 36)
                // noise: any code, including the unknown ones
                queue_tok(5'($urandom_range(0, 31)), $urandom);
            else
            begin
                op = 5'($urandom_range(CMD_SWAP, CMD_NOP));
                if (op == CMD_PUT || op == CMD_PICK || op == CMD_ONLY)
                begin
                    // mostly in-range index, sometimes negative or too deep
                    if ($urandom_range(0, 7) == 0)
                        idx = $urandom_range(0, 1) ? 32'hffff_ffff : d;
                    else if (op == CMD_PUT)
                        idx = $urandom_range(0, d - 2);
                    else
                        idx = $urandom_range(0, d - 1);
                    queue_tok(CMD_LIT, idx);
                end
                queue_tok(op, $urandom);
                case (op)
                    CMD_DUP:  d++;
                    CMD_PUT:  d--;
                    CMD_PICK: d++;
                    CMD_ONLY: d = 1;
                    CMD_DROP: d--;
                    CMD_SWAP, CMD_NOT, CMD_NOP: ;
                    default:  d--;
                endcase
            end
        end
        // usually reduce to a single value so the result is a real number
        while (d > 1 && (!allow_now || $urandom_range(0, 1) == 0)
               && $urandom_range(0, 9) != 0)
        begin
            queue_tok(5'($urandom_range(CMD_ADD, CMD_XOR)), $urandom);
            d--;
        end
    endtask

    // Directed: extremes, division corners, every error but empty/overflow.
    task automatic directed_part();
        queue_tok(CMD_LIT, 32'h7fff_ffff);
        queue_tok(CMD_LIT, 32'd1);
        queue_tok(CMD_ADD, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'h8000_0000);
        queue_tok(CMD_LIT, 32'hffff_ffff);
        queue_tok(CMD_DIV, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'h8000_0000);
        queue_tok(CMD_LIT, 32'hffff_ffff);
        queue_tok(CMD_MOD, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'hffff_fff9);
        queue_tok(CMD_LIT, 32'd0);
        queue_tok(CMD_DIV, 32'd0);
        send_expr();
        queue_tok(CMD_ADD, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'd3);
        queue_tok(CMD_LIT, 32'd5);
        queue_tok(CMD_PICK, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'd3);
        queue_tok(CMD_LIT, 32'd4);
        queue_tok(5'd31, 32'hffff_ffff);
        send_expr();
        queue_tok(CMD_LIT, 32'd3);
        queue_tok(5'd28, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'h8000_0001);
        queue_tok(CMD_LIT, 32'd33);
        queue_tok(CMD_SHR, 32'd0);
        send_expr();
        queue_tok(CMD_LIT, 32'd1);
        queue_tok(CMD_LIT, 32'd2);
        send_expr();
        queue_tok(CMD_NOP, 32'd0);
        send_expr();
    endtask

    initial
    begin
        rst_n = 1'b0;
        tok_valid = 1'b0;
        tok = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        allow_now = 1'b0;
        burst_mode = 1'b0;
        tokens_sent = 0;
        settings_used = 1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_part();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_VART, 32'h7fff_ffff);
                    write_reg(REG_ALLOW, 32'd1);
                end
                1:
                begin
                    write_reg(REG_VART, 32'h8000_0000);
                    write_reg(REG_ALLOW, 32'd0);
                end
                default:
                begin
                    write_reg(REG_VART, $urandom);
                    write_reg(REG_ALLOW, 32'($urandom_range(0, 1)));
                end
            endcase
            // empty stack with leftovers allowed is its own status
            queue_tok(CMD_VART, 32'd0);
            queue_tok(CMD_DROP, 32'd0);
            send_expr();
            for (int n = 0; n < 50; n += 0)
            begin
                burst_mode = ($urandom_range(0, 7) == 0);
                build_expr();
                n += expr_q.size();
                send_expr();
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
            burst_mode = 1'b0;
        end

        // fill the stack past its depth
        for (int k = 0; k <= DEPTH; k++)
            queue_tok(k[0] ? CMD_DUP : CMD_LIT, $urandom);
        send_expr();

        drain();
        repeat (100) @(negedge clk);
        $display("Covered %0d tokens and %0d expression results (%0d with error status)",
                 tokens_sent, results_seen, error_results);
        $display("across %0d register settings, including both extremes of variable_t",
                 settings_used);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule
